/* hw/rtl/dcrc_pkg.sv */
// Package: payload types and CRC-16 (0x8005) helpers for the dual-order CRC check.
`timescale 1ns / 1ps
`default_nettype none

package dcrc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_ZERO = 16'h0000;

    // Input request: one data byte, end mark and reference CRC
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] reference_crc;
    } t_dcrc_in;

    // Result request: both CRC forms and the match flag
    typedef struct packed {
        logic [15:0] crc_msb_first;
        logic [15:0] crc_reflected;
        logic        ref_match;
    } t_dcrc_out;

    // Running CRC registers (reflected one held before its final reversal)
    typedef struct packed {
        logic [15:0] normal;
        logic [15:0] reflected;
    } t_dcrc_state;

    // Shift one byte MSB first through the CRC
    function automatic logic [15:0] crc_byte_msb(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            if (c[15] ^ data[i]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

    function automatic logic [15:0] rev16(input logic [15:0] w);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = w[15 - i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/dcrc_core.sv */
// Combinational byte update of both CRC registers and end-of-block result.
`timescale 1ns / 1ps
`default_nettype none

module dcrc_core (
    input  wire  dcrc_pkg::t_dcrc_state i_state,
    input  wire  dcrc_pkg::t_dcrc_in    i_req,
    output dcrc_pkg::t_dcrc_state       o_state,
    output dcrc_pkg::t_dcrc_out         o_result
);
    import dcrc_pkg::*;

    logic [15:0] upd_normal;
    logic [15:0] upd_reflected;
    logic [15:0] crc_r_out;

    // Advance both CRCs by one byte
    always_comb begin
        upd_normal    = crc_byte_msb(i_state.normal, i_req.data_byte);
        upd_reflected = crc_byte_msb(i_state.reflected, rev8(i_req.data_byte));
        crc_r_out     = rev16(upd_reflected);
    end

    // Form the result and clear the registers at end of block
    always_comb begin
        o_result.crc_msb_first = upd_normal;
        o_result.crc_reflected = crc_r_out;
        o_result.ref_match     = (upd_normal == i_req.reference_crc) ||
                                 (crc_r_out == i_req.reference_crc);
        if (i_req.last_byte) begin
            o_state.normal    = CRC_ZERO;
            o_state.reflected = CRC_ZERO;
        end else begin
            o_state.normal    = upd_normal;
            o_state.reflected = upd_reflected;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dual_order_crc16_check.sv */
// Top level: dual-order CRC-16 block check with input and result registers.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one byte per
//   request, with last_byte marking the final byte of a block and
//   reference_crc sampled on that byte only.
//   Result channel (o_out_valid / i_out_stall / o_out_data) gives one request
//   per block: MSB-first CRC, reflected (ARC form) CRC and a match flag.
//   Throughput: one byte per cycle while the result slot is not blocked,
//   set by the single byte-wide XOR update between the input register and
//   the CRC/result registers. The last byte of a block sits in the input
//   register, then loads the result register when the input stage advances.
//   Reset (synchronous, active low) empties both stages and clears both CRC
//   registers to zero.
//   When the receiver stalls, the result register holds; the input register
//   holds one more byte, and then o_in_stall rises until the result is taken.
//   Non-last bytes keep flowing as long as the result slot is not blocked.
`timescale 1ns / 1ps
`default_nettype none

module dual_order_crc16_check (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  dcrc_pkg::t_dcrc_in  i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output dcrc_pkg::t_dcrc_out    o_out_data
);
    import dcrc_pkg::*;

    logic        r_in_valid;
    t_dcrc_in    r_in;
    t_dcrc_state r_state;
    t_dcrc_state n_state;
    t_dcrc_out   r_out;
    t_dcrc_out   n_out;
    logic        r_out_valid;
    logic        s1_adv;
    logic        in_take;

    // Advance the input stage unless the result slot is blocked
    assign s1_adv     = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !s1_adv;
    assign in_take    = i_in_valid && !o_in_stall;

    dcrc_core u_core (
        .i_state  (r_state),
        .i_req    (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (s1_adv) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // CRC registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_adv) begin
            r_state <= n_state;
        end
    end

    // Result register: load on last byte, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (s1_adv && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_in.last_byte) |=> (r_state.normal == CRC_ZERO &&
                                         r_state.reflected == CRC_ZERO))
        else $error("CRC registers not cleared after end of block");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result lost or changed");

endmodule

`default_nettype wire
